>>> sv/icps_pkg.sv
package icps_pkg;

  // Configuration register width (image_width, image_height)
  localparam int CFG_W = 9;

  // Input command codes
  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_SAMPLE  = 2'd2;

  // Configuration register indexes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] pixel_value;
    logic [31:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [7:0] column;
    logic [7:0] row;
    logic       status;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic capture;
    logic rd_total;
    logic check;
    logic rd_mid;
    logic step;
    logic div_start;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sample_ok;
    logic lo_lt_hi;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

>>> sv/icps_if.sv
interface icps_in_if;
  logic               valid;
  logic               ready;
  icps_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface icps_out_if;
  logic                valid;
  logic                ready;
  icps_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/image_cdf_pixel_sampler.sv
// Load and restart transactions complete in the idle state, which then accepts the next item.
// A sample reads the total, checks it and forms the target, then binary-searches the store;
// each search step reads through the single read port, then compares. The column/row divider
// then yields one quotient bit per cycle. One item is in work at a time.
// Reset (rst_ni low, asynchronous): loaded count and running total clear, width and height
// return to 1, the output channel empties; the cumulative store is not cleared.
module image_cdf_pixel_sampler #(
  parameter int MAX_PIXELS = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  icps_in_if.sink           in_i,
  icps_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Register 0 (image_width) at byte 0, register 1
  // (image_height) at byte 4; decode on paddr[2], word aligned. The port has no
  // wait states, so a write lands on the access cycle.
  // ---------------------------------------------------------------------------
  logic [icps_pkg::CFG_W-1:0] width_q;
  logic [icps_pkg::CFG_W-1:0] height_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= icps_pkg::CFG_W'(1);
      height_q <= icps_pkg::CFG_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == icps_pkg::REG_WIDTH) width_q <= pwdata[icps_pkg::CFG_W-1:0];
      if (paddr[2] == icps_pkg::REG_HEIGHT) height_q <= pwdata[icps_pkg::CFG_W-1:0];
    end
  end

  // Read back the selected register, zero extended
  assign prdata = (paddr[2] == icps_pkg::REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

  // ---------------------------------------------------------------------------
  // Controller: accepts one input transaction when idle, then sequences the sample: read
  // total, check and form target, binary search and divide (both skipped on a failed check), emit.
  // ---------------------------------------------------------------------------
  icps_pkg::dp_cmd_t  dp_cmd;
  icps_pkg::dp_stat_t dp_stat;

  icps_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.data.command),
    .in_ready_o   (in_i.ready),
    .stat_i       (dp_stat),
    .cmd_o        (dp_cmd)
  );

  // ---------------------------------------------------------------------------
  // Datapath: cumulative store, running total, target multiply, search bounds,
  // index divider and the output register. The output register lets loads
  // continue while a finished sample waits for the sink.
  // ---------------------------------------------------------------------------
  icps_dpath #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .width_i     (width_q),
    .height_i    (height_q),
    .in_data_i   (in_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

>>> sv/icps_ctrl.sv
module icps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_command_i,
  output logic              in_ready_o,
  input  icps_pkg::dp_stat_t stat_i,
  output icps_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_TOT,
    S_CHECK,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DIV,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_command_i)
            icps_pkg::CMD_RESTART: cmd_o.clear = 1'b1;
            icps_pkg::CMD_LOAD:    cmd_o.load  = 1'b1;
            icps_pkg::CMD_SAMPLE: begin
              cmd_o.capture = 1'b1;
              state_d       = S_RD_TOT;
            end
            default: ;
          endcase
        end
      end
      S_RD_TOT: begin
        cmd_o.rd_total = 1'b1;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = stat_i.sample_ok ? S_SRCH_RD : S_EMIT;
      end
      S_SRCH_RD: begin
        if (stat_i.lo_lt_hi) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = S_SRCH_CMP;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_SRCH_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = S_SRCH_RD;
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/icps_div.sv
module icps_div #(
  parameter int DW = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DW-1:0]              dividend_i,
  input  logic [icps_pkg::CFG_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [DW-1:0]              quot_o,
  output logic [icps_pkg::CFG_W-1:0] rem_o
);

  localparam int CW = $clog2(DW + 1);
  localparam int RW = icps_pkg::CFG_W;

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quot_q;
  logic [RW-1:0] rem_q;
  logic [RW:0]   shifted;
  logic [RW+1:0] diff;
  logic          fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_q, quot_q[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_i};
  assign fits    = ~diff[RW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[RW-1:0] : shifted[RW-1:0];
      quot_q <= DW'({quot_q, fits});
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

>>> sv/icps_dpath.sv
module icps_dpath #(
  parameter int MAX_PIXELS = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  icps_pkg::dp_cmd_t          cmd_i,
  output icps_pkg::dp_stat_t         stat_o,
  input  logic [icps_pkg::CFG_W-1:0] width_i,
  input  logic [icps_pkg::CFG_W-1:0] height_i,
  input  icps_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output icps_pkg::out_item_t        out_data_o
);

  localparam int AW  = $clog2(MAX_PIXELS);
  localparam int LCW = $clog2(MAX_PIXELS + 1);
  localparam int RAW = 2 * icps_pkg::CFG_W;
  localparam int PW  = (LCW > RAW) ? LCW : RAW;

  // Pixel count, clamped to the store depth
  logic [RAW-1:0] n_raw;
  logic [PW-1:0]  n_ext;
  logic [LCW-1:0] n;
  logic [LCW-1:0] n_m1;

  assign n_raw = width_i * height_i;
  assign n_ext = PW'(n_raw);
  assign n     = (n_ext > PW'(MAX_PIXELS)) ? LCW'(MAX_PIXELS) : LCW'(n_ext);
  assign n_m1  = n - 1'b1;

  // Loading
  logic [LCW-1:0] loaded_q;
  logic [31:0]    total_q;
  logic [32:0]    sum_wide;
  logic [31:0]    sum_sat;
  logic           load_en;

  assign load_en  = cmd_i.load && (loaded_q < n);
  assign sum_wide = {1'b0, total_q} + 33'(in_data_i.pixel_value);
  assign sum_sat  = sum_wide[32] ? '1 : sum_wide[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      total_q  <= '0;
    end else if (cmd_i.clear) begin
      loaded_q <= '0;
      total_q  <= '0;
    end else if (load_en) begin
      loaded_q <= loaded_q + 1'b1;
      total_q  <= sum_sat;
    end
  end

  // Cumulative store: one write port, one registered read port
  logic [31:0]   mem_q [MAX_PIXELS];
  logic [31:0]   rdata_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] lo_q, hi_q, mid;

  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_addr = cmd_i.rd_total ? n_m1[AW-1:0] : mid;

  always_ff @(posedge clk_i) begin
    if (load_en) mem_q[loaded_q[AW-1:0]] <= sum_sat;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_total || cmd_i.rd_mid) rdata_q <= mem_q[rd_addr];
  end

  // Sample: total check, target, search bounds
  logic [31:0] frac_q;
  logic [31:0] target_q;
  logic [63:0] prod;
  logic        fail_q;
  logic        sample_ok;

  assign sample_ok = (n != '0) && (loaded_q >= n) && (rdata_q != '0);
  assign prod      = 64'(frac_q) * 64'(rdata_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) frac_q <= in_data_i.random_fraction;
    if (cmd_i.check) begin
      fail_q   <= ~sample_ok;
      target_q <= prod[63:32];
      lo_q     <= '0;
      hi_q     <= n_m1[AW-1:0];
    end else if (cmd_i.step) begin
      if (rdata_q > target_q) hi_q <= mid;
      else                    lo_q <= mid + 1'b1;
    end
  end

  // Index to column and row
  logic                       div_done;
  logic [AW-1:0]              quot;
  logic [icps_pkg::CFG_W-1:0] rem;

  icps_div #(
    .DW(AW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (lo_q),
    .divisor_i  (width_i),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // Output register
  logic                out_valid_q;
  icps_pkg::out_item_t out_q;
  logic                out_free;

  assign out_free = ~out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.column <= fail_q ? 8'd0 : 8'(rem);
      out_q.row    <= fail_q ? 8'd0 : 8'(quot);
      out_q.status <= fail_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.sample_ok = sample_ok;
  assign stat_o.lo_lt_hi  = lo_q < hi_q;
  assign stat_o.div_done  = div_done;
  assign stat_o.out_free  = out_free;

endmodule
